/* rtl/slm_pkg.sv */
// ----------------------------------------------------------------------------
// slm_pkg
// shared widths, command codes and controller/datapath structs for the merger
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int C_DEPTH = 32;
    localparam int CMD_W   = 2;
    localparam int VAL_W   = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;

    typedef struct packed {
        logic push_a;
        logic push_b;
        logic start;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic slot_free;
        logic last;
    } t_dp_sts;

endpackage

/* rtl/slm_if.sv */
// ----------------------------------------------------------------------------
// slm_if
// valid/ready channels for input items and merged results
// ----------------------------------------------------------------------------
interface slm_in_if;
    import slm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface slm_out_if;
    import slm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  merged_value;
    logic                     last;

    modport source (output valid, output merged_value, output last, input ready);
    modport sink   (input valid, input merged_value, input last, output ready);
endinterface

/* rtl/slm_ctrl.sv */
// ----------------------------------------------------------------------------
// slm_ctrl
// controller: decodes input items and sequences the merge; unless the output stalls, one result a cycle
// ----------------------------------------------------------------------------
module slm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [slm_pkg::CMD_W-1:0]  i_in_command,
    output logic                       o_in_ready,
    output slm_pkg::t_dp_cmd           o_cmd,
    input  slm_pkg::t_dp_sts           i_sts
);
    import slm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_MERGE = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    assign in_xfer = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.push_a = in_xfer && (i_in_command == CMD_PUSH_A);
                o_cmd.push_b = in_xfer && (i_in_command == CMD_PUSH_B);
                if (in_xfer && (i_in_command == CMD_MERGE) && !i_sts.empty) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_MERGE;
                end
            end
            S_MERGE: begin
                o_cmd.emit = i_sts.slot_free;
                if (i_sts.slot_free && i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/slm_dp.sv */
// ----------------------------------------------------------------------------
// slm_dp
// datapath: two list memories, fill counts, merge pointers and output register
// ----------------------------------------------------------------------------
module slm_dp #(
    parameter int DEPTH = slm_pkg::C_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  slm_pkg::t_dp_cmd                  i_cmd,
    output slm_pkg::t_dp_sts                  o_sts,
    input  logic signed [slm_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [slm_pkg::VAL_W-1:0]  o_merged_value,
    output logic                              o_last
);
    import slm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic signed [VAL_W-1:0] r_mem_a [DEPTH];
    logic signed [VAL_W-1:0] r_mem_b [DEPTH];
    logic signed [VAL_W-1:0] r_head_a;
    logic signed [VAL_W-1:0] r_head_b;
    logic [CW-1:0]           r_cnt_a;
    logic [CW-1:0]           r_cnt_b;
    logic [CW-1:0]           r_ia;
    logic [CW-1:0]           r_ib;
    logic [CW-1:0]           n_ia;
    logic [CW-1:0]           n_ib;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_last;
    logic                    take_a;
    logic                    last;

    assign take_a = (r_ia < r_cnt_a) &&
                    ((r_ib >= r_cnt_b) || (r_head_a <= r_head_b));

    always_comb begin
        n_ia = r_ia;
        n_ib = r_ib;
        if (i_cmd.start) begin
            n_ia = '0;
            n_ib = '0;
        end else if (i_cmd.emit) begin
            if (take_a) begin
                n_ia = r_ia + 1'b1;
            end else begin
                n_ib = r_ib + 1'b1;
            end
        end
    end

    assign last            = (n_ia == r_cnt_a) && (n_ib == r_cnt_b);
    assign o_sts.empty     = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_sts.last      = last;

    // list memories, read ahead at the next pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_a && (r_cnt_a != FULL)) begin
            r_mem_a[r_cnt_a[AW-1:0]] <= i_value;
        end
        if (i_cmd.push_b && (r_cnt_b != FULL)) begin
            r_mem_b[r_cnt_b[AW-1:0]] <= i_value;
        end
        r_head_a <= r_mem_a[n_ia[AW-1:0]];
        r_head_b <= r_mem_b[n_ib[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ia <= n_ia;
            r_ib <= n_ib;
            if (i_cmd.emit && last) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
            end else begin
                if (i_cmd.push_a && (r_cnt_a != FULL)) begin
                    r_cnt_a <= r_cnt_a + 1'b1;
                end
                if (i_cmd.push_b && (r_cnt_b != FULL)) begin
                    r_cnt_b <= r_cnt_b + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_value <= take_a ? r_head_a : r_head_b;
            r_out_last  <= last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_last         = r_out_last;

endmodule

/* rtl/sorted_list_merge.sv */
// ----------------------------------------------------------------------------
// sorted_list_merge
// loads two ascending lists and merges them, A first on equal values
//
//   channel  | dir | payload                 | transfer
//   i_in     | in  | command, value          | i_in.valid & i_in.ready
//   o_out    | out | merged_value, last      | o_out.valid & o_out.ready
//
// a push writes one list memory; a merge, once accepted, yields one result per
// cycle from the two list memories, count_a + count_b results in total;
// input is held off while a merge is emitting; an output stall pauses it
// synchronous active-low reset clears the counts, pointers and state
// ----------------------------------------------------------------------------
module sorted_list_merge #(
    parameter int DEPTH = slm_pkg::C_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slm_in_if.sink     i_in,
    slm_out_if.source  o_out
);
    import slm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    slm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .o_in_ready   (i_in.ready),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    slm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_value        (i_in.value),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_merged_value (o_out.merged_value),
        .o_last         (o_out.last)
    );

endmodule

/* test/sorted_list_merge_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_merge_chk
// scoreboard for the sorted list merger
//
// Watches both channels. Each input transfer updates a local copy of the two
// lists. A merge command runs the two-pointer merge on that copy and queues
// the merged values, with the final one flagged. Each output transfer is
// checked field by field against the oldest queued value. The failure count
// and the number of values still awaited go back to the testbench top.
// ----------------------------------------------------------------------------
module sorted_list_merge_chk #(
    parameter int DEPTH = slm_pkg::C_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    slm_in_if    i_in,
    slm_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import slm_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] merged_value;
        logic                    last;
    } t_merged;

    logic signed [VAL_W-1:0] list_a [DEPTH];
    logic signed [VAL_W-1:0] list_b [DEPTH];
    int                      fill_a;
    int                      fill_b;
    int                      fails;
    int                      checked;
    t_merged                 merged_q [$];

    // two-pointer merge, A wins on equal heads
    task automatic merge_lists();
        int      ia;
        int      ib;
        int      total;
        t_merged m;
        ia    = 0;
        ib    = 0;
        total = fill_a + fill_b;
        for (int k = 0; k < total; k++) begin
            if (ia < fill_a && (ib >= fill_b || list_a[ia] <= list_b[ib])) begin
                m.merged_value = list_a[ia];
                ia++;
            end else begin
                m.merged_value = list_b[ib];
                ib++;
            end
            m.last = (k + 1 == total);
            merged_q.push_back(m);
        end
        fill_a = 0;
        fill_b = 0;
    endtask

    task automatic check_result();
        t_merged exp_r;
        checked++;
        if (merged_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got value %0d last %0b",
                     $time, i_out.merged_value, i_out.last);
            fails++;
        end else begin
            exp_r = merged_q.pop_front();
            if (i_out.merged_value !== exp_r.merged_value) begin
                $display("%0t: merged_value mismatch, expected %0d, got %0d",
                         $time, exp_r.merged_value, i_out.merged_value);
                fails++;
            end
            if (i_out.last !== exp_r.last) begin
                $display("%0t: last mismatch, expected %0b, got %0b",
                         $time, exp_r.last, i_out.last);
                fails++;
            end
        end
    endtask

    initial begin
        fill_a  = 0;
        fill_b  = 0;
        fails   = 0;
        checked = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_a = 0;
            fill_b = 0;
            merged_q.delete();
        end else begin
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                check_result();
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                case (i_in.command)
                    CMD_PUSH_A: begin
                        if (fill_a < DEPTH) begin
                            list_a[fill_a] = i_in.value;
                            fill_a++;
                        end
                    end
                    CMD_PUSH_B: begin
                        if (fill_b < DEPTH) begin
                            list_b[fill_b] = i_in.value;
                            fill_b++;
                        end
                    end
                    CMD_MERGE: begin
                        merge_lists();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= merged_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

/* test/sorted_list_merge_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_merge_tb
// stimulus and verdict for the sorted list merger
//
// After reset a short directed run covers empty merges, the unused command,
// the extremes of the value range, ties between the lists, unsorted lists and
// merges with one side empty. A random run follows, mostly sorted loads of
// random length and content followed by a merge, including both lists pushed
// past full, mixed with bursts of random commands. Both sides idle at random
// apart from one calm stretch. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module sorted_list_merge_tb;
    import slm_pkg::*;

    localparam logic [CMD_W-1:0]        CMD_UNUSED  = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN     = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX     = 32'sh7fff_ffff;
    localparam int                      IDLE_PCT    = 13;
    localparam int                      RAND_ITEMS  = 140;
    localparam int                      STALL_LIMIT = 2000;
    localparam int                      DRAIN_WAIT  = 8;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   checked;
    int   n_items;
    int   n_merges;
    int   lvl_a;
    int   lvl_b;
    int   stall_cycles;

    slm_in_if  in_ch ();
    slm_out_if out_ch ();

    sorted_list_merge #(
        .DEPTH (C_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sorted_list_merge_chk #(
        .DEPTH (C_DEPTH)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side back-pressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // no transfer on either channel for too long
    initial stall_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("sorted_list_merge_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int rand_val(input bit narrow);
        return narrow ? int'($urandom_range(0, 15)) - 8 : int'($urandom);
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.value   <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        case (cmd)
            CMD_PUSH_A: begin
                if (lvl_a < C_DEPTH) begin
                    lvl_a++;
                    n_items++;
                end
            end
            CMD_PUSH_B: begin
                if (lvl_b < C_DEPTH) begin
                    lvl_b++;
                    n_items++;
                end
            end
            CMD_MERGE: begin
                lvl_a = 0;
                lvl_b = 0;
                n_items++;
                n_merges++;
            end
            default: begin
            end
        endcase
    endtask

    // sorted random content, pushes to the two lists interleaved at random
    task automatic load_and_merge(input int na, input int nb, input bit narrow);
        int va [$];
        int vb [$];
        int ia;
        int ib;
        repeat (na) va.push_back(rand_val(narrow));
        repeat (nb) vb.push_back(rand_val(narrow));
        va.sort();
        vb.sort();
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
                send_item(CMD_PUSH_A, va[ia]);
                ia++;
            end else begin
                send_item(CMD_PUSH_B, vb[ib]);
                ib++;
            end
        end
        send_item(CMD_MERGE, $urandom);
    endtask

    task automatic noise_burst();
        int r;
        repeat ($urandom_range(1, 10)) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                send_item(CMD_PUSH_A, $urandom);
            end else if (r < 8) begin
                send_item(CMD_PUSH_B, $urandom);
            end else if (r == 8) begin
                send_item(CMD_UNUSED, $urandom);
            end else begin
                send_item(CMD_MERGE, $urandom);
            end
        end
    endtask

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return C_DEPTH + $urandom_range(0, 2);
        end else if (r == 1) begin
            return $urandom_range(C_DEPTH / 2, C_DEPTH);
        end
        return $urandom_range(0, 6);
    endfunction

    initial begin
        int start_items;
        int seq;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_PUSH_A;
        in_ch.value   = '0;
        i_rst_n       = 1'b0;
        calm          = 1'b0;
        n_items       = 0;
        n_merges      = 0;
        lvl_a         = 0;
        lvl_b         = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty merge, unused command
        send_item(CMD_MERGE, '0);
        send_item(CMD_UNUSED, VAL_MAX);
        // range extremes, tie at the top value
        send_item(CMD_PUSH_A, VAL_MIN);
        send_item(CMD_PUSH_A, '0);
        send_item(CMD_PUSH_A, VAL_MAX);
        send_item(CMD_PUSH_B, -1);
        send_item(CMD_PUSH_B, VAL_MAX);
        send_item(CMD_MERGE, VAL_MIN);
        // unsorted A, tie inside B, unused command during loading
        send_item(CMD_PUSH_A, 10);
        send_item(CMD_PUSH_A, 3);
        send_item(CMD_PUSH_B, 5);
        send_item(CMD_UNUSED, 7);
        send_item(CMD_PUSH_B, 5);
        send_item(CMD_MERGE, '0);
        // one side empty
        send_item(CMD_PUSH_B, 42);
        send_item(CMD_MERGE, '0);
        send_item(CMD_PUSH_A, -7);
        send_item(CMD_MERGE, '0);

        // both lists pushed past full
        start_items = n_items;
        load_and_merge(C_DEPTH + 2, C_DEPTH + 1, 1'b0);
        seq = 0;
        while (n_items - start_items < RAND_ITEMS) begin
            calm <= (seq >= 6 && seq < 14);
            if ($urandom_range(0, 9) < 7) begin
                load_and_merge(pick_size(), pick_size(), $urandom_range(0, 2) == 0);
            end else begin
                noise_burst();
            end
            seq++;
        end
        send_item(CMD_MERGE, '0);
        in_ch.valid <= 1'b0;
        calm        <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d items transferred in, %0d merge commands", n_items, n_merges);
        $display("%0d merged results checked", checked);
        if (fail_count == 0) begin
            $display("sorted_list_merge_tb: PASS");
        end else begin
            $display("sorted_list_merge_tb: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/slm_pkg.sv
rtl/slm_if.sv
rtl/slm_ctrl.sv
rtl/slm_dp.sv
rtl/sorted_list_merge.sv
test/sorted_list_merge_chk.sv
test/sorted_list_merge_tb.sv
